[rtl/small_array_table_engine_unit_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the small array table engine checker
// Clocked on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef SMALL_ARRAY_TABLE_ENGINE_UNIT_ASSERT_SVH
`define SMALL_ARRAY_TABLE_ENGINE_UNIT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SATE_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define SATE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

[rtl/sate_pkg.sv]
// ----------------------------------------------------------------------------
// sate_pkg
// Sizes, codes, RAM request type and field conversions for the table engine.
// ----------------------------------------------------------------------------
package sate_pkg;

    localparam int CAPACITY  = 16;
    localparam int WORD_BITS = 32;

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);

    localparam int OPCODE_W   = 3;
    localparam int VALUE_W    = 32;
    localparam int STATUS_W   = 2;
    localparam int ELEMENT_W  = 32;
    localparam int POSITION_W = 4;
    localparam int FILL_W     = 5;

    localparam logic [OPCODE_W-1:0] OP_SEARCH  = 3'd0;
    localparam logic [OPCODE_W-1:0] OP_INSERT  = 3'd1;
    localparam logic [OPCODE_W-1:0] OP_DELETE  = 3'd2;
    localparam logic [OPCODE_W-1:0] OP_REPLACE = 3'd3;
    localparam logic [OPCODE_W-1:0] OP_REVERSE = 3'd4;
    localparam logic [OPCODE_W-1:0] OP_SHOW    = 3'd5;

    localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NOTFOUND = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL     = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY    = 2'd3;

    localparam int VEXT_W = (WORD_BITS > VALUE_W) ? WORD_BITS : VALUE_W;
    localparam int EEXT_W = (WORD_BITS > ELEMENT_W) ? WORD_BITS : ELEMENT_W;
    localparam int PEXT_W = (CNT_W > POSITION_W) ? CNT_W : POSITION_W;
    localparam int FEXT_W = (CNT_W > FILL_W) ? CNT_W : FILL_W;

    typedef logic [WORD_BITS-1:0] word_t;

    typedef struct packed {
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
        word_t            wr_data;
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
    } ram_req_t;

    // Sign-extend a 32-bit field, then cut to the word width.
    function automatic word_t to_word(logic signed [VALUE_W-1:0] v);
        logic signed [VEXT_W-1:0] e;
        e = VEXT_W'(v);
        return e[WORD_BITS-1:0];
    endfunction

    function automatic logic [ELEMENT_W-1:0] to_element(word_t w);
        logic [EEXT_W-1:0] e;
        e = EEXT_W'(w);
        return e[ELEMENT_W-1:0];
    endfunction

    function automatic logic [POSITION_W-1:0] to_position(logic [CNT_W-1:0] c);
        logic [PEXT_W-1:0] e;
        e = PEXT_W'(c);
        return e[POSITION_W-1:0];
    endfunction

    function automatic logic [FILL_W-1:0] to_fill(logic [CNT_W-1:0] c);
        logic [FEXT_W-1:0] e;
        e = FEXT_W'(c);
        return e[FILL_W-1:0];
    endfunction

endpackage

[rtl/sate_ram.sv]
// ----------------------------------------------------------------------------
// sate_ram
// Table storage: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module sate_ram
(
    input  logic               clk,
    input  sate_pkg::ram_req_t req,
    output sate_pkg::word_t    rd_data
);

    sate_pkg::word_t mem [sate_pkg::CAPACITY];
    sate_pkg::word_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
    end

    // Hold read data until the next read.
    always_ff @(posedge clk)
    begin
        if (req.rd_en)
        begin
            rd_data_reg <= mem[req.rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/small_array_table_engine_unit.sv]
// ----------------------------------------------------------------------------
// small_array_table_engine_unit
// Bounded table of signed words with search, insert, delete, replace,
// reverse and show commands, run by a sequencer over one RAM port pair.
// ----------------------------------------------------------------------------
// Insert, unused codes and empty-table cases load their result on accept; search
// and replace walk the filled entries; delete walks them, then moves later entries
// down unless the match is the last one; reverse swaps pairs inwards from the ends;
// show gives one result per entry. One item at a time, the next taken the cycle after
// the last result leaves; the single read port and entry compare set the walk rate.
// Reset clears the fill count and sequencer; table contents are not cleared.
module small_array_table_engine_unit
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // [31:0] key_value, [63:32] new_value
    input  logic [2:0]  s_tuser,   // [2:0] opcode

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // [0] present, [32:1] element, [36:33] position,
                                   // [41:37] fill_now, [47:42] zero
    output logic [1:0]  m_tuser,   // [1:0] status
    output logic        m_tlast
);

    localparam int CNT_W = sate_pkg::CNT_W;
    localparam int IDX_W = sate_pkg::IDX_W;

    // Sequencer states
    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_SCAN      = 4'd1;  // walk entries, compare with key
    localparam logic [3:0] S_SHIFT     = 4'd2;  // move entries down after delete
    localparam logic [3:0] S_REV_RA    = 4'd3;  // read low entry of pair
    localparam logic [3:0] S_REV_RB    = 4'd4;  // read high entry, hold low
    localparam logic [3:0] S_REV_WA    = 4'd5;  // write high value to low slot
    localparam logic [3:0] S_REV_WB    = 4'd6;  // write low value to high slot
    localparam logic [3:0] S_SHOW_LD   = 4'd7;  // load shown entry into output
    localparam logic [3:0] S_SHOW_WAIT = 4'd8;  // wait for shown entry to leave
    localparam logic [3:0] S_OUT       = 4'd9;  // wait for single result to leave

    localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);
    localparam logic [CNT_W-1:0] CNT_CAP = CNT_W'(sate_pkg::CAPACITY);

    logic [3:0] state_reg, state_next;

    // Command held for the duration of the walk
    logic [sate_pkg::OPCODE_W-1:0] op_reg, op_next;
    sate_pkg::word_t               key_reg, key_next;
    sate_pkg::word_t               repl_reg, repl_next;
    logic [CNT_W-1:0]              n_reg, n_next;

    // Walk pointers: ra = next read index, ck = index of data in rd_data
    logic [CNT_W-1:0] ra_reg, ra_next;
    logic [CNT_W-1:0] ck_reg, ck_next;
    logic             ck_vld_reg, ck_vld_next;
    logic             hit_reg, hit_next;
    logic [CNT_W-1:0] loc_reg, loc_next;
    logic [CNT_W-1:0] lo_reg, lo_next;
    logic [CNT_W-1:0] hi_reg, hi_next;
    sate_pkg::word_t  tmp_reg, tmp_next;

    logic [CNT_W-1:0] fill_reg, fill_next;

    // Output register
    logic                            out_vld_reg, out_vld_next;
    logic [sate_pkg::STATUS_W-1:0]   status_reg;
    logic                            present_reg;
    logic [sate_pkg::ELEMENT_W-1:0]  element_reg;
    logic [sate_pkg::POSITION_W-1:0] position_reg;
    logic [sate_pkg::FILL_W-1:0]     fill_out_reg;
    logic                            last_reg;

    // Result load strobe and values
    logic                            ld;
    logic [sate_pkg::STATUS_W-1:0]   ld_status;
    logic                            ld_present;
    logic [sate_pkg::ELEMENT_W-1:0]  ld_element;
    logic [sate_pkg::POSITION_W-1:0] ld_position;
    logic                            ld_last;

    sate_pkg::ram_req_t ram_req;
    sate_pkg::word_t    rd_data;

    // Shared compare unit and walk end detection
    logic             match;
    logic             last_ck;
    logic             del_hit;
    logic [CNT_W-1:0] del_loc;

    assign match   = ck_vld_reg && (rd_data == key_reg);
    assign last_ck = ck_vld_reg && (ck_reg == n_reg - CNT_ONE);
    assign del_hit = hit_reg || match;
    assign del_loc = match ? ck_reg : loc_reg;

    sate_ram u_ram
    (
        .clk     (clk),
        .req     (ram_req),
        .rd_data (rd_data)
    );

    always_comb
    begin
        state_next   = state_reg;
        op_next      = op_reg;
        key_next     = key_reg;
        repl_next    = repl_reg;
        n_next       = n_reg;
        ra_next      = ra_reg;
        ck_next      = ck_reg;
        ck_vld_next  = ck_vld_reg;
        hit_next     = hit_reg;
        loc_next     = loc_reg;
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        tmp_next     = tmp_reg;
        fill_next    = fill_reg;
        out_vld_next = out_vld_reg;

        ld          = 1'b0;
        ld_status   = sate_pkg::STATUS_OK;
        ld_present  = 1'b0;
        ld_element  = '0;
        ld_position = '0;
        ld_last     = 1'b1;

        ram_req         = '0;
        ram_req.rd_addr = ra_reg[IDX_W-1:0];

        s_tready = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    // Latch the command and prime the walk pointers.
                    op_next     = s_tuser;
                    key_next    = sate_pkg::to_word($signed(s_tdata[31:0]));
                    repl_next   = sate_pkg::to_word($signed(s_tdata[63:32]));
                    n_next      = fill_reg;
                    ra_next     = '0;
                    ck_next     = '0;
                    ck_vld_next = 1'b0;
                    hit_next    = 1'b0;
                    loc_next    = '0;
                    lo_next     = '0;
                    hi_next     = fill_reg - CNT_ONE;
                    unique case (s_tuser)
                        sate_pkg::OP_SEARCH:
                        begin
                            if (fill_reg == '0)
                            begin
                                ld         = 1'b1;
                                ld_status  = sate_pkg::STATUS_NOTFOUND;
                                state_next = S_OUT;
                            end
                            else
                            begin
                                state_next = S_SCAN;
                            end
                        end
                        sate_pkg::OP_INSERT:
                        begin
                            ld         = 1'b1;
                            state_next = S_OUT;
                            if (fill_reg >= CNT_CAP)
                            begin
                                ld_status = sate_pkg::STATUS_FULL;
                            end
                            else
                            begin
                                // Append at the end of the filled part.
                                ram_req.wr_en   = 1'b1;
                                ram_req.wr_addr = fill_reg[IDX_W-1:0];
                                ram_req.wr_data =
                                    sate_pkg::to_word($signed(s_tdata[31:0]));
                                fill_next       = fill_reg + CNT_ONE;
                            end
                        end
                        sate_pkg::OP_DELETE:
                        begin
                            if (fill_reg == '0)
                            begin
                                ld         = 1'b1;
                                ld_status  = sate_pkg::STATUS_NOTFOUND;
                                state_next = S_OUT;
                            end
                            else
                            begin
                                state_next = S_SCAN;
                            end
                        end
                        sate_pkg::OP_REPLACE:
                        begin
                            if (fill_reg == '0)
                            begin
                                ld         = 1'b1;
                                state_next = S_OUT;
                            end
                            else
                            begin
                                state_next = S_SCAN;
                            end
                        end
                        sate_pkg::OP_REVERSE:
                        begin
                            if (fill_reg < CNT_W'(2))
                            begin
                                ld         = 1'b1;
                                state_next = S_OUT;
                            end
                            else
                            begin
                                state_next = S_REV_RA;
                            end
                        end
                        sate_pkg::OP_SHOW:
                        begin
                            if (fill_reg == '0)
                            begin
                                ld         = 1'b1;
                                ld_status  = sate_pkg::STATUS_EMPTY;
                                state_next = S_OUT;
                            end
                            else
                            begin
                                // Fetch entry zero now; S_SHOW_LD loads it into the output register.
                                ram_req.rd_en   = 1'b1;
                                ram_req.rd_addr = '0;
                                state_next      = S_SHOW_LD;
                            end
                        end
                        default:
                        begin
                            // Unused codes leave the table alone.
                            ld         = 1'b1;
                            state_next = S_OUT;
                        end
                    endcase
                end
            end

            S_SCAN:
            begin
                // Issue one read a cycle while checking the previous one.
                if (ra_reg < n_reg)
                begin
                    ram_req.rd_en = 1'b1;
                    ra_next       = ra_reg + CNT_ONE;
                end
                ck_vld_next = ram_req.rd_en;
                ck_next     = ra_reg;
                unique case (op_reg)
                    sate_pkg::OP_SEARCH:
                    begin
                        if (match)
                        begin
                            ld         = 1'b1;
                            ld_present = 1'b1;
                            state_next = S_OUT;
                        end
                        else if (last_ck)
                        begin
                            ld         = 1'b1;
                            ld_status  = sate_pkg::STATUS_NOTFOUND;
                            state_next = S_OUT;
                        end
                    end
                    sate_pkg::OP_REPLACE:
                    begin
                        if (match)
                        begin
                            ram_req.wr_en   = 1'b1;
                            ram_req.wr_addr = ck_reg[IDX_W-1:0];
                            ram_req.wr_data = repl_reg;
                        end
                        if (last_ck)
                        begin
                            ld         = 1'b1;
                            state_next = S_OUT;
                        end
                    end
                    default:
                    begin
                        // Delete: remember the last matching index.
                        if (match)
                        begin
                            hit_next = 1'b1;
                            loc_next = ck_reg;
                        end
                        if (last_ck)
                        begin
                            if (!del_hit)
                            begin
                                ld         = 1'b1;
                                ld_status  = sate_pkg::STATUS_NOTFOUND;
                                state_next = S_OUT;
                            end
                            else if (del_loc == n_reg - CNT_ONE)
                            begin
                                // Last entry removed: nothing to move.
                                fill_next  = n_reg - CNT_ONE;
                                ld         = 1'b1;
                                state_next = S_OUT;
                            end
                            else
                            begin
                                ra_next     = del_loc + CNT_ONE;
                                ck_vld_next = 1'b0;
                                state_next  = S_SHIFT;
                            end
                        end
                    end
                endcase
            end

            S_SHIFT:
            begin
                // Read entry i+1 and write it to slot i on the next cycle.
                if (ra_reg < n_reg)
                begin
                    ram_req.rd_en = 1'b1;
                    ra_next       = ra_reg + CNT_ONE;
                end
                ck_vld_next = ram_req.rd_en;
                ck_next     = ra_reg;
                if (ck_vld_reg)
                begin
                    ram_req.wr_en   = 1'b1;
                    ram_req.wr_addr = ck_reg[IDX_W-1:0] - IDX_W'(1);
                    ram_req.wr_data = rd_data;
                end
                if (last_ck)
                begin
                    fill_next  = n_reg - CNT_ONE;
                    ld         = 1'b1;
                    state_next = S_OUT;
                end
            end

            S_REV_RA:
            begin
                ram_req.rd_en   = 1'b1;
                ram_req.rd_addr = lo_reg[IDX_W-1:0];
                state_next      = S_REV_RB;
            end

            S_REV_RB:
            begin
                ram_req.rd_en   = 1'b1;
                ram_req.rd_addr = hi_reg[IDX_W-1:0];
                tmp_next        = rd_data;
                state_next      = S_REV_WA;
            end

            S_REV_WA:
            begin
                ram_req.wr_en   = 1'b1;
                ram_req.wr_addr = lo_reg[IDX_W-1:0];
                ram_req.wr_data = rd_data;
                state_next      = S_REV_WB;
            end

            S_REV_WB:
            begin
                ram_req.wr_en   = 1'b1;
                ram_req.wr_addr = hi_reg[IDX_W-1:0];
                ram_req.wr_data = tmp_reg;
                lo_next         = lo_reg + CNT_ONE;
                hi_next         = hi_reg - CNT_ONE;
                // Advance to the next pair while the pointers have not met.
                if ((lo_reg + CNT_ONE) < (hi_reg - CNT_ONE))
                begin
                    state_next = S_REV_RA;
                end
                else
                begin
                    ld         = 1'b1;
                    state_next = S_OUT;
                end
            end

            S_SHOW_LD:
            begin
                ld          = 1'b1;
                ld_element  = sate_pkg::to_element(rd_data);
                ld_position = sate_pkg::to_position(ra_reg);
                ld_last     = (ra_reg == n_reg - CNT_ONE);
                state_next  = S_SHOW_WAIT;
            end

            S_SHOW_WAIT:
            begin
                if (m_tready)
                begin
                    out_vld_next = 1'b0;
                    if (last_reg)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        ram_req.rd_en   = 1'b1;
                        ram_req.rd_addr = ra_reg[IDX_W-1:0] + IDX_W'(1);
                        ra_next         = ra_reg + CNT_ONE;
                        state_next      = S_SHOW_LD;
                    end
                end
            end

            S_OUT:
            begin
                if (m_tready)
                begin
                    out_vld_next = 1'b0;
                    state_next   = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (ld)
        begin
            out_vld_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            fill_reg    <= '0;
            out_vld_reg <= 1'b0;
            ck_vld_reg  <= 1'b0;
            hit_reg     <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            fill_reg    <= fill_next;
            out_vld_reg <= out_vld_next;
            ck_vld_reg  <= ck_vld_next;
            hit_reg     <= hit_next;
        end
    end

    // Command and walk payload
    always_ff @(posedge clk)
    begin
        op_reg   <= op_next;
        key_reg  <= key_next;
        repl_reg <= repl_next;
        n_reg    <= n_next;
        ra_reg   <= ra_next;
        ck_reg   <= ck_next;
        loc_reg  <= loc_next;
        lo_reg   <= lo_next;
        hi_reg   <= hi_next;
        tmp_reg  <= tmp_next;
    end

    // Result payload: load once, hold while the item waits.
    always_ff @(posedge clk)
    begin
        if (ld)
        begin
            status_reg   <= ld_status;
            present_reg  <= ld_present;
            element_reg  <= ld_element;
            position_reg <= ld_position;
            fill_out_reg <= sate_pkg::to_fill(fill_next);
            last_reg     <= ld_last;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {6'd0, fill_out_reg, position_reg, element_reg, present_reg};
    assign m_tuser  = status_reg;
    assign m_tlast  = last_reg;

endmodule

[rtl/sate_checker.sv]
// ----------------------------------------------------------------------------
// sate_checker
// Port-level checks of the table engine, bound to the top level.
// ----------------------------------------------------------------------------
`include "small_array_table_engine_unit_assert.svh"

module sate_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata,
    input logic [1:0]  m_tuser,
    input logic        m_tlast
);

    // Idle means no result is left waiting.
    `SATE_ASSERT_SAME(a_idle_no_result, s_tready, !m_tvalid)

    // Hold off the next item once one is taken.
    `SATE_ASSERT_NEXT(a_one_at_a_time, s_tvalid && s_tready, !s_tready)

    // Only show gives non-final results, and those carry ok status with present clear.
    `SATE_ASSERT_SAME(a_mid_show_ok, m_tvalid && !m_tlast,
                      (m_tuser == sate_pkg::STATUS_OK) && !m_tdata[0])

    // A stalled result holds.
    `SATE_ASSERT_NEXT(a_stall_hold, m_tvalid && !m_tready,
                      m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))

endmodule

bind small_array_table_engine_unit sate_checker u_sate_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
